// File: design/rgbrle_pkg.sv
`timescale 1ns / 1ps

package rgbrle_pkg;

    // configured frame limits, already clamped to the build maximums
    typedef struct packed {
        logic [17:0] frame_pixels;
        logic [19:0] stream_bytes;
    } rgbrle_cfg_t;

    // one result: pixel segment or final frame status
    typedef struct packed {
        logic        kind;
        logic        status;
        logic [15:0] pixel_value;
        logic [16:0] start_index;
        logic [15:0] repeat_count;
        logic        frame_done;
    } rgbrle_result_t;

    localparam logic KIND_SEGMENT = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    // result queue between the decoder and the output port
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

endpackage

// File: design/rgbrle_decode.sv
`timescale 1ns / 1ps

module rgbrle_decode
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       restart,
    input  rgbrle_pkg::rgbrle_cfg_t    cfg,
    input  logic                       take,
    input  logic [7:0]                 data_byte,
    output logic                       seg_valid,
    output rgbrle_pkg::rgbrle_result_t seg,
    output logic                       stat_valid,
    output rgbrle_pkg::rgbrle_result_t stat
);

    localparam logic [2:0] PH_CTRL_LO = 3'd0;
    localparam logic [2:0] PH_CTRL_HI = 3'd1;
    localparam logic [2:0] PH_PIX_LO  = 3'd2;
    localparam logic [2:0] PH_PIX_HI  = 3'd3;
    localparam logic [2:0] PH_SWALLOW = 3'd4;

    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  hold_reg, hold_next;
    logic        run_reg, run_next;
    logic [15:0] left_reg, left_next;
    logic [17:0] idx_reg, idx_next;
    logic [19:0] taken_reg, taken_next;

    logic [19:0] taken_inc;
    logic [15:0] ctrl_word;
    logic [15:0] count;
    logic [19:0] bytes_left;
    logic [16:0] need;
    logic [17:0] pix_owed;
    logic [15:0] pix_word;
    logic [17:0] idx_after;
    logic [15:0] left_after;
    logic        fin;
    logic        fin_ok;

    always_comb
    begin
        taken_inc  = taken_reg + 20'd1;
        ctrl_word  = {data_byte, hold_reg};
        count      = {1'b0, ctrl_word[14:0]} + 16'd1;
        bytes_left = cfg.stream_bytes - taken_inc;
        need       = ctrl_word[15] ? 17'd2 : {count, 1'b0};
        pix_owed   = cfg.frame_pixels - idx_reg;
        pix_word   = {data_byte, hold_reg};
        idx_after  = run_reg ? (idx_reg + {2'd0, left_reg}) : (idx_reg + 18'd1);
        left_after = run_reg ? 16'd0 : (left_reg - 16'd1);

        phase_next = phase_reg;
        hold_next  = hold_reg;
        run_next   = run_reg;
        left_next  = left_reg;
        idx_next   = idx_reg;
        taken_next = taken_reg;
        fin        = 1'b0;
        fin_ok     = 1'b0;

        seg_valid        = 1'b0;
        seg.kind         = rgbrle_pkg::KIND_SEGMENT;
        seg.status       = rgbrle_pkg::STATUS_OK;
        seg.pixel_value  = pix_word;
        seg.start_index  = idx_reg[16:0];
        seg.repeat_count = run_reg ? left_reg : 16'd1;
        seg.frame_done   = 1'b0;

        stat_valid        = 1'b0;
        stat.kind         = rgbrle_pkg::KIND_STATUS;
        stat.status       = rgbrle_pkg::STATUS_ERR;
        stat.pixel_value  = '0;
        stat.start_index  = '0;
        stat.repeat_count = '0;
        stat.frame_done   = 1'b1;

        if (phase_reg == PH_SWALLOW)
        begin
            taken_next = taken_inc;
            if (taken_inc >= cfg.stream_bytes)
            begin
                phase_next = PH_CTRL_LO;
                hold_next  = '0;
                run_next   = 1'b0;
                left_next  = '0;
                idx_next   = '0;
                taken_next = '0;
            end
        end
        else if (taken_reg >= cfg.stream_bytes)
        begin
            // empty stream: byte dropped, verdict of an empty frame
            stat_valid  = 1'b1;
            stat.status = (cfg.frame_pixels == 18'd0) ? rgbrle_pkg::STATUS_OK
                                                      : rgbrle_pkg::STATUS_ERR;
            phase_next  = PH_CTRL_LO;
            hold_next   = '0;
            run_next    = 1'b0;
            left_next   = '0;
            idx_next    = '0;
            taken_next  = '0;
        end
        else
        begin
            taken_next = taken_inc;
            unique case (phase_reg)
                PH_CTRL_LO:
                begin
                    if (idx_reg >= cfg.frame_pixels)
                    begin
                        fin = 1'b1;
                    end
                    else
                    begin
                        hold_next = data_byte;
                        if (taken_inc >= cfg.stream_bytes)
                        begin
                            fin = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_CTRL_HI;
                        end
                    end
                end
                PH_CTRL_HI:
                begin
                    run_next = ctrl_word[15];
                    if (({2'd0, count} > pix_owed) || ({3'd0, need} > bytes_left))
                    begin
                        fin = 1'b1;
                    end
                    else
                    begin
                        left_next  = count;
                        phase_next = PH_PIX_LO;
                    end
                end
                PH_PIX_LO:
                begin
                    hold_next  = data_byte;
                    phase_next = PH_PIX_HI;
                end
                PH_PIX_HI:
                begin
                    seg_valid = 1'b1;
                    idx_next  = idx_after;
                    left_next = left_after;
                    if (left_after != 16'd0)
                    begin
                        phase_next = PH_PIX_LO;
                    end
                    else if (idx_after >= cfg.frame_pixels)
                    begin
                        fin    = 1'b1;
                        fin_ok = (taken_inc == cfg.stream_bytes);
                    end
                    else if (taken_inc >= cfg.stream_bytes)
                    begin
                        fin = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_CTRL_LO;
                    end
                end
                default:
                begin
                    phase_next = PH_CTRL_LO;
                end
            endcase

            if (fin)
            begin
                stat_valid  = 1'b1;
                stat.status = fin_ok ? rgbrle_pkg::STATUS_OK : rgbrle_pkg::STATUS_ERR;
                if (taken_inc < cfg.stream_bytes)
                begin
                    phase_next = PH_SWALLOW;
                end
                else
                begin
                    phase_next = PH_CTRL_LO;
                    hold_next  = '0;
                    run_next   = 1'b0;
                    left_next  = '0;
                    idx_next   = '0;
                    taken_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_CTRL_LO;
            hold_reg  <= '0;
            run_reg   <= 1'b0;
            left_reg  <= '0;
            idx_reg   <= '0;
            taken_reg <= '0;
        end
        else if (restart)
        begin
            phase_reg <= PH_CTRL_LO;
            hold_reg  <= '0;
            run_reg   <= 1'b0;
            left_reg  <= '0;
            idx_reg   <= '0;
            taken_reg <= '0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            hold_reg  <= hold_next;
            run_reg   <= run_next;
            left_reg  <= left_next;
            idx_reg   <= idx_next;
            taken_reg <= taken_next;
        end
    end

endmodule

// File: design/rgb565_rle_stream_decoder_top.sv
`timescale 1ns / 1ps

// rgb565 run-length stream decoder. takes the compressed frame one byte per
// cycle on the in_valid/in_ready channel and turns each decoded pixel into a
// segment request (pixel_value, start_index, repeat_count) on the out channel,
// closing every frame with exactly one status request (kind 1, frame_done 1,
// status 0 ok / 1 size error). a byte is decoded in the cycle it is accepted;
// each byte gives at most two requests, which go into a four-entry result
// queue, so in_ready drops only while fewer than two queue slots are free.
// with out_ready held high the block sustains one byte per clock; a byte's
// results are registered in the queue behind any unpopped entries. the user
// must write frame_pixels (addr 0) and stream_bytes (addr 4) over apb only
// while the block is idle, not enforced here; any write restarts the decoder.
module rgb565_rle_stream_decoder_top
#(
    parameter int MAX_PIXELS       = 131072,
    parameter int MAX_STREAM_BYTES = 1048576
)
(
    input  logic        clk,
    input  logic        rst_n,

    // apb register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    // compressed byte stream
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,

    // decoded segment / status requests
    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic        status,
    output logic [15:0] pixel_value,
    output logic [16:0] start_index,
    output logic [15:0] repeat_count,
    output logic        frame_done
);

    // register select on paddr[2]
    localparam logic REG_FRAME_PIXELS = 1'b0;
    localparam logic REG_STREAM_BYTES = 1'b1;

    // clamp values for oversized register contents
    localparam logic [17:0] PIX_CAP  = (MAX_PIXELS > 262143) ? 18'h3ffff
                                                             : 18'(MAX_PIXELS);
    localparam logic [19:0] BYTE_CAP = (MAX_STREAM_BYTES > 1048575) ? 20'hfffff
                                                                    : 20'(MAX_STREAM_BYTES);
    localparam logic [17:0] FP_RESET     = 18'd129600;
    localparam logic [17:0] FP_EFF_RESET = (129600 > MAX_PIXELS) ? PIX_CAP : FP_RESET;

    logic [17:0] frame_pixels_reg;
    logic [19:0] stream_bytes_reg;
    rgbrle_pkg::rgbrle_cfg_t cfg_reg;

    logic        wr_en;
    logic        take;
    logic [17:0] fp_wr;
    logic [19:0] sb_wr;

    logic                       seg_valid;
    rgbrle_pkg::rgbrle_result_t seg;
    logic                       stat_valid;
    rgbrle_pkg::rgbrle_result_t stat;

    rgbrle_pkg::rgbrle_result_t          q_mem [rgbrle_pkg::OUTQ_DEPTH];
    logic [rgbrle_pkg::OUTQ_AW-1:0]      wp_reg;
    logic [rgbrle_pkg::OUTQ_AW-1:0]      rp_reg;
    logic [rgbrle_pkg::OUTQ_CW-1:0]      cnt_reg;
    logic [rgbrle_pkg::OUTQ_CW-1:0]      push_n;
    logic                                pop;
    rgbrle_pkg::rgbrle_result_t          head;

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign fp_wr  = pwdata[17:0];
    assign sb_wr  = pwdata[19:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_pixels_reg     <= FP_RESET;
            stream_bytes_reg     <= '0;
            cfg_reg.frame_pixels <= FP_EFF_RESET;
            cfg_reg.stream_bytes <= '0;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_FRAME_PIXELS:
                begin
                    frame_pixels_reg     <= fp_wr;
                    // clamp once here so the decoder sees the effective limit
                    cfg_reg.frame_pixels <= ({14'd0, fp_wr} > 32'(MAX_PIXELS)) ? PIX_CAP
                                                                              : fp_wr;
                end
                REG_STREAM_BYTES:
                begin
                    stream_bytes_reg     <= sb_wr;
                    cfg_reg.stream_bytes <= ({12'd0, sb_wr} > 32'(MAX_STREAM_BYTES))
                                            ? BYTE_CAP : sb_wr;
                end
                default:
                begin
                    frame_pixels_reg <= frame_pixels_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_FRAME_PIXELS: prdata = {14'd0, frame_pixels_reg};
            REG_STREAM_BYTES: prdata = {12'd0, stream_bytes_reg};
            default:          prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // decoder: one byte per accepted request
    // ---------------------------------------------------------------
    assign take = in_valid & in_ready;

    rgbrle_decode u_decode
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .restart    (wr_en),
        .cfg        (cfg_reg),
        .take       (take),
        .data_byte  (data_byte),
        .seg_valid  (seg_valid),
        .seg        (seg),
        .stat_valid (stat_valid),
        .stat       (stat)
    );

    // ---------------------------------------------------------------
    // result queue: segment first, then status when a byte gives both
    // ---------------------------------------------------------------
    assign in_ready = (cnt_reg <= rgbrle_pkg::OUTQ_CW'(rgbrle_pkg::OUTQ_DEPTH - 2));
    assign out_valid = (cnt_reg != '0);
    assign pop       = out_valid & out_ready;
    assign push_n    = take ? (rgbrle_pkg::OUTQ_CW'(seg_valid) +
                               rgbrle_pkg::OUTQ_CW'(stat_valid)) : '0;

    always_ff @(posedge clk)
    begin
        if (take && seg_valid)
        begin
            q_mem[wp_reg] <= seg;
        end
        if (take && stat_valid)
        begin
            q_mem[seg_valid ? (wp_reg + 1'b1) : wp_reg] <= stat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_reg + rgbrle_pkg::OUTQ_AW'(push_n);
            rp_reg  <= rp_reg + rgbrle_pkg::OUTQ_AW'(pop);
            cnt_reg <= cnt_reg + push_n - rgbrle_pkg::OUTQ_CW'(pop);
        end
    end

    assign head         = q_mem[rp_reg];
    assign kind         = head.kind;
    assign status       = head.status;
    assign pixel_value  = head.pixel_value;
    assign start_index  = head.start_index;
    assign repeat_count = head.repeat_count;
    assign frame_done   = head.frame_done;

endmodule
